// ----- design/rsct_pkg.sv -----
// Shared types, defaults and helpers for the rectangle shape collision test unit.
// No dependencies; imported by rsct_place and the top level.
`default_nettype none

package rsct_pkg;

    localparam int POS_WIDTH_DEF    = 16;
    localparam int OFFSET_WIDTH_DEF = 12;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TEST = 1'b1;

    localparam logic SHAPE_RECT   = 1'b0;
    localparam logic SHAPE_CIRCLE = 1'b1;

    typedef struct packed {
        logic valid;
        logic early_hit;
        logic corner_en;
    } t_stage_ctl;

    // width of a placed world edge: position plus a flipped offset, with headroom
    function automatic int edge_w(input int pos_w, input int off_w);
        int wide;
        wide = (pos_w > off_w + 2) ? pos_w : off_w + 2;
        return wide + 1;
    endfunction

endpackage

`default_nettype wire

// ----- design/rsct_place.sv -----
// Places a shape in world space: adds offsets to the object position, flips them
// when mirrored and sorts the rectangle edges. Depends on rsct_pkg.
`default_nettype none

module rsct_place #(
    parameter int POS_WIDTH    = rsct_pkg::POS_WIDTH_DEF,
    parameter int OFFSET_WIDTH = rsct_pkg::OFFSET_WIDTH_DEF,
    localparam int EW          = rsct_pkg::edge_w(POS_WIDTH, OFFSET_WIDTH)
) (
    input  logic signed [POS_WIDTH-1:0]    i_pos_x,
    input  logic signed [POS_WIDTH-1:0]    i_pos_y,
    input  logic                           i_mirrored,
    input  logic        [OFFSET_WIDTH-1:0] i_frame_width,
    input  logic signed [OFFSET_WIDTH-1:0] i_geom_a,
    input  logic signed [OFFSET_WIDTH-1:0] i_geom_b,
    input  logic signed [OFFSET_WIDTH-1:0] i_geom_c,
    input  logic signed [OFFSET_WIDTH-1:0] i_geom_d,
    output logic signed [EW-1:0]           o_left,
    output logic signed [EW-1:0]           o_right,
    output logic signed [EW-1:0]           o_top,
    output logic signed [EW-1:0]           o_bottom,
    output logic signed [EW-1:0]           o_cx,
    output logic signed [EW-1:0]           o_cy
);
    import rsct_pkg::*;

    logic signed [EW-1:0] w_px;
    logic signed [EW-1:0] w_py;
    logic signed [EW-1:0] w_fw;
    logic signed [EW-1:0] w_a;
    logic signed [EW-1:0] w_b;
    logic signed [EW-1:0] w_c;
    logic signed [EW-1:0] w_d;
    logic signed [EW-1:0] w_x1;
    logic signed [EW-1:0] w_x2;
    logic signed [EW-1:0] w_y1;
    logic signed [EW-1:0] w_y2;

    assign w_px = EW'(i_pos_x);
    assign w_py = EW'(i_pos_y);
    assign w_fw = signed'(EW'(i_frame_width));
    assign w_a  = EW'(i_geom_a);
    assign w_b  = EW'(i_geom_b);
    assign w_c  = EW'(i_geom_c);
    assign w_d  = EW'(i_geom_d);

    assign w_x1 = i_mirrored ? (w_px + (w_fw - w_a)) : (w_px + w_a);
    assign w_x2 = i_mirrored ? (w_px + (w_fw - w_c)) : (w_px + w_c);
    assign w_y1 = w_py + w_b;
    assign w_y2 = w_py + w_d;

    always_comb begin
        o_left   = (w_x1 < w_x2) ? w_x1 : w_x2;
        o_right  = (w_x1 < w_x2) ? w_x2 : w_x1;
        o_top    = (w_y1 < w_y2) ? w_y1 : w_y2;
        o_bottom = (w_y1 < w_y2) ? w_y2 : w_y1;
    end

    assign o_cx = w_x1;
    assign o_cy = w_y1;

endmodule

`default_nettype wire

// ----- design/rsct_corner_sq.sv -----
// Registered squaring stage for the circle corner test: squares the four
// corner deltas and the radius. No package dependencies.
`default_nettype none

module rsct_corner_sq #(
    parameter int DW = 18,
    parameter int RW = 12
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [DW-1:0] i_dx_left,
    input  logic signed [DW-1:0] i_dx_right,
    input  logic signed [DW-1:0] i_dy_top,
    input  logic signed [DW-1:0] i_dy_bottom,
    input  logic signed [RW-1:0] i_radius,
    output logic [2*DW-1:0]      o_sq_left,
    output logic [2*DW-1:0]      o_sq_right,
    output logic [2*DW-1:0]      o_sq_top,
    output logic [2*DW-1:0]      o_sq_bottom,
    output logic [2*RW-1:0]      o_sq_radius
);

    logic signed [2*DW-1:0] n_sq_left;
    logic signed [2*DW-1:0] n_sq_right;
    logic signed [2*DW-1:0] n_sq_top;
    logic signed [2*DW-1:0] n_sq_bottom;
    logic signed [2*RW-1:0] n_sq_radius;

    logic [2*DW-1:0] r_sq_left;
    logic [2*DW-1:0] r_sq_right;
    logic [2*DW-1:0] r_sq_top;
    logic [2*DW-1:0] r_sq_bottom;
    logic [2*RW-1:0] r_sq_radius;

    assign n_sq_left   = i_dx_left * i_dx_left;
    assign n_sq_right  = i_dx_right * i_dx_right;
    assign n_sq_top    = i_dy_top * i_dy_top;
    assign n_sq_bottom = i_dy_bottom * i_dy_bottom;
    assign n_sq_radius = i_radius * i_radius;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_left   <= unsigned'(n_sq_left);
            r_sq_right  <= unsigned'(n_sq_right);
            r_sq_top    <= unsigned'(n_sq_top);
            r_sq_bottom <= unsigned'(n_sq_bottom);
            r_sq_radius <= unsigned'(n_sq_radius);
        end
    end

    assign o_sq_left   = r_sq_left;
    assign o_sq_right  = r_sq_right;
    assign o_sq_top    = r_sq_top;
    assign o_sq_bottom = r_sq_bottom;
    assign o_sq_radius = r_sq_radius;

endmodule

`default_nettype wire

// ----- design/rect_shape_collision_test_unit.sv -----
// Top level of the rectangle shape collision test unit: input register, subject
// edge store, box and circle tests, corner squares and result register.
// Depends on rsct_pkg, rsct_place and rsct_corner_sq.
// A test request's hit goes through the evaluate and corner-square stages to o_valid.
// Throughput: one request per cycle while o_stall is low; loads and tests mix freely.
// Four register stages (input, evaluate, corner square, result) advance together
// whenever the result register is empty or taken.
// Reset clears all stage valids and sets the subject to a zero-size box at the origin.
`default_nettype none

module rect_shape_collision_test_unit #(
    parameter int POS_WIDTH    = rsct_pkg::POS_WIDTH_DEF,
    parameter int OFFSET_WIDTH = rsct_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_action,
    input  logic                           i_other_is_circle,
    input  logic signed [POS_WIDTH-1:0]    i_pos_x,
    input  logic signed [POS_WIDTH-1:0]    i_pos_y,
    input  logic                           i_mirrored,
    input  logic        [OFFSET_WIDTH-1:0] i_frame_width,
    input  logic signed [OFFSET_WIDTH-1:0] i_geom_a,
    input  logic signed [OFFSET_WIDTH-1:0] i_geom_b,
    input  logic signed [OFFSET_WIDTH-1:0] i_geom_c,
    input  logic signed [OFFSET_WIDTH-1:0] i_geom_d,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_hit
);
    import rsct_pkg::*;

    localparam int EW = edge_w(POS_WIDTH, OFFSET_WIDTH);
    localparam int SW = EW + 3;
    localparam int CW = EW + 1;
    localparam int QW = 2 * CW + 1;

    logic w_adv;

    logic                           r_in_valid;
    logic                           r_in_action;
    logic                           r_in_circle;
    logic signed [POS_WIDTH-1:0]    r_in_pos_x;
    logic signed [POS_WIDTH-1:0]    r_in_pos_y;
    logic                           r_in_mirrored;
    logic        [OFFSET_WIDTH-1:0] r_in_frame_width;
    logic signed [OFFSET_WIDTH-1:0] r_in_geom_a;
    logic signed [OFFSET_WIDTH-1:0] r_in_geom_b;
    logic signed [OFFSET_WIDTH-1:0] r_in_geom_c;
    logic signed [OFFSET_WIDTH-1:0] r_in_geom_d;

    logic signed [EW-1:0] r_subj_left;
    logic signed [EW-1:0] r_subj_right;
    logic signed [EW-1:0] r_subj_top;
    logic signed [EW-1:0] r_subj_bottom;

    logic signed [EW-1:0] w_left;
    logic signed [EW-1:0] w_right;
    logic signed [EW-1:0] w_top;
    logic signed [EW-1:0] w_bottom;
    logic signed [EW-1:0] w_cx;
    logic signed [EW-1:0] w_cy;

    logic signed [SW-1:0] w_dx_raw;
    logic signed [SW-1:0] w_dy_raw;
    logic signed [SW-1:0] w_dx;
    logic signed [SW-1:0] w_dy;
    logic signed [SW-1:0] w_ex;
    logic signed [SW-1:0] w_ey;
    logic                 w_box_hit;

    logic signed [CW-1:0] w_rad;
    logic signed [CW-1:0] w_ccx;
    logic signed [CW-1:0] w_ccy;
    logic                 w_inx;
    logic                 w_iny;
    logic                 w_band_y;
    logic                 w_band_x;
    logic                 w_rad_pos;

    t_stage_ctl           n_s1_ctl;
    t_stage_ctl           r_s1_ctl;
    t_stage_ctl           r_s2_ctl;
    logic signed [CW-1:0] n_dx_left;
    logic signed [CW-1:0] n_dx_right;
    logic signed [CW-1:0] n_dy_top;
    logic signed [CW-1:0] n_dy_bottom;
    logic signed [CW-1:0] r_s1_dx_left;
    logic signed [CW-1:0] r_s1_dx_right;
    logic signed [CW-1:0] r_s1_dy_top;
    logic signed [CW-1:0] r_s1_dy_bottom;
    logic signed [OFFSET_WIDTH-1:0] r_s1_radius;

    logic [2*CW-1:0]         w_sq_left;
    logic [2*CW-1:0]         w_sq_right;
    logic [2*CW-1:0]         w_sq_top;
    logic [2*CW-1:0]         w_sq_bottom;
    logic [2*OFFSET_WIDTH-1:0] w_sq_radius;
    logic [QW-1:0]           w_rr;
    logic                    w_corner_hit;
    logic                    n_hit;

    logic r_out_valid;
    logic r_out_hit;

    assign w_adv   = !r_out_valid || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_out_valid;
    assign o_hit   = r_out_hit;

    rsct_place #(
        .POS_WIDTH   (POS_WIDTH),
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_place (
        .i_pos_x      (r_in_pos_x),
        .i_pos_y      (r_in_pos_y),
        .i_mirrored   (r_in_mirrored),
        .i_frame_width(r_in_frame_width),
        .i_geom_a     (r_in_geom_a),
        .i_geom_b     (r_in_geom_b),
        .i_geom_c     (r_in_geom_c),
        .i_geom_d     (r_in_geom_d),
        .o_left       (w_left),
        .o_right      (w_right),
        .o_top        (w_top),
        .o_bottom     (w_bottom),
        .o_cx         (w_cx),
        .o_cy         (w_cy)
    );

    // box against box on doubled coordinates
    assign w_dx_raw = (SW'(r_subj_left) + SW'(r_subj_right)) - (SW'(w_left) + SW'(w_right));
    assign w_dy_raw = (SW'(r_subj_top) + SW'(r_subj_bottom)) - (SW'(w_top) + SW'(w_bottom));
    assign w_dx     = w_dx_raw[SW-1] ? -w_dx_raw : w_dx_raw;
    assign w_dy     = w_dy_raw[SW-1] ? -w_dy_raw : w_dy_raw;
    assign w_ex     = (SW'(r_subj_right) - SW'(r_subj_left)) + (SW'(w_right) - SW'(w_left));
    assign w_ey     = (SW'(r_subj_bottom) - SW'(r_subj_top)) + (SW'(w_bottom) - SW'(w_top));
    assign w_box_hit = (w_dx < w_ex) && (w_dy < w_ey);

    // circle against box
    assign w_rad     = CW'(r_in_geom_c);
    assign w_ccx     = CW'(w_cx);
    assign w_ccy     = CW'(w_cy);
    assign w_rad_pos = !r_in_geom_c[OFFSET_WIDTH-1] && (r_in_geom_c != '0);
    assign w_inx     = (w_cx < r_subj_right) && (w_cx > r_subj_left);
    assign w_iny     = (w_cy < r_subj_bottom) && (w_cy > r_subj_top);
    assign w_band_y  = w_inx && (w_ccy < CW'(r_subj_bottom) + w_rad)
                             && (w_ccy > CW'(r_subj_top) - w_rad);
    assign w_band_x  = w_iny && (w_ccx < CW'(r_subj_right) + w_rad)
                             && (w_ccx > CW'(r_subj_left) - w_rad);

    assign n_dx_left   = CW'(r_subj_left) - w_ccx;
    assign n_dx_right  = CW'(r_subj_right) - w_ccx;
    assign n_dy_top    = CW'(r_subj_top) - w_ccy;
    assign n_dy_bottom = CW'(r_subj_bottom) - w_ccy;

    always_comb begin
        n_s1_ctl.valid = r_in_valid && (r_in_action == ACT_TEST);
        case (r_in_circle)
            SHAPE_CIRCLE: begin
                n_s1_ctl.early_hit = (w_inx && w_iny) || w_band_y || w_band_x;
                n_s1_ctl.corner_en = w_rad_pos;
            end
            default: begin
                n_s1_ctl.early_hit = w_box_hit;
                n_s1_ctl.corner_en = 1'b0;
            end
        endcase
    end

    rsct_corner_sq #(
        .DW(CW),
        .RW(OFFSET_WIDTH)
    ) u_corner_sq (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_dx_left  (r_s1_dx_left),
        .i_dx_right (r_s1_dx_right),
        .i_dy_top   (r_s1_dy_top),
        .i_dy_bottom(r_s1_dy_bottom),
        .i_radius   (r_s1_radius),
        .o_sq_left  (w_sq_left),
        .o_sq_right (w_sq_right),
        .o_sq_top   (w_sq_top),
        .o_sq_bottom(w_sq_bottom),
        .o_sq_radius(w_sq_radius)
    );

    assign w_rr = QW'(w_sq_radius);
    assign w_corner_hit = r_s2_ctl.corner_en &&
        ((QW'(w_sq_left)  + QW'(w_sq_top))    < w_rr ||
         (QW'(w_sq_left)  + QW'(w_sq_bottom)) < w_rr ||
         (QW'(w_sq_right) + QW'(w_sq_top))    < w_rr ||
         (QW'(w_sq_right) + QW'(w_sq_bottom)) < w_rr);
    assign n_hit = r_s2_ctl.early_hit || w_corner_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_s1_ctl      <= '0;
            r_s2_ctl      <= '0;
            r_out_valid   <= 1'b0;
            r_subj_left   <= '0;
            r_subj_right  <= '0;
            r_subj_top    <= '0;
            r_subj_bottom <= '0;
        end else if (w_adv) begin
            r_in_valid  <= i_valid;
            r_s1_ctl    <= n_s1_ctl;
            r_s2_ctl    <= r_s1_ctl;
            r_out_valid <= r_s2_ctl.valid;
            if (r_in_valid && (r_in_action == ACT_LOAD)) begin
                r_subj_left   <= w_left;
                r_subj_right  <= w_right;
                r_subj_top    <= w_top;
                r_subj_bottom <= w_bottom;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_action      <= i_action;
            r_in_circle      <= i_other_is_circle;
            r_in_pos_x       <= i_pos_x;
            r_in_pos_y       <= i_pos_y;
            r_in_mirrored    <= i_mirrored;
            r_in_frame_width <= i_frame_width;
            r_in_geom_a      <= i_geom_a;
            r_in_geom_b      <= i_geom_b;
            r_in_geom_c      <= i_geom_c;
            r_in_geom_d      <= i_geom_d;
            r_s1_dx_left     <= n_dx_left;
            r_s1_dx_right    <= n_dx_right;
            r_s1_dy_top      <= n_dy_top;
            r_s1_dy_bottom   <= n_dy_bottom;
            r_s1_radius      <= r_in_geom_c;
            r_out_hit        <= n_hit;
        end
    end

    a_subject_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_subj_left <= r_subj_right) && (r_subj_top <= r_subj_bottom))
        else $error("subject edges out of order");

    a_subject_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_subj_left) && $stable(r_subj_right) &&
                    $stable(r_subj_top) && $stable(r_subj_bottom))
        else $error("subject changed while stalled");

    a_only_tests_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_valid |=> r_s1_ctl.valid == $past(r_in_action == ACT_TEST))
        else $error("request kind lost entering evaluate stage");

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s2_ctl.valid))
        else $error("result without a test request behind it");

    a_corner_needs_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_ctl.corner_en |-> !r_s1_radius[OFFSET_WIDTH-1] && (r_s1_radius != '0))
        else $error("corner test armed with non-positive radius");

endmodule

`default_nettype wire
